>>> src/ahs_pkg.sv
// ---------------------------------------------------------------------------
// ahs_pkg
// Shared types, constants and the sine table generator of the additive
// harmonic synthesiser.
// ---------------------------------------------------------------------------
package ahs_pkg;

    localparam int MAX_HARMONICS_DEF  = 16;
    localparam int SINE_DEPTH_DEF     = 1024;
    localparam int COUNTER_BITS_DEF   = 24;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [2:0] CFG_NOTE_NAME      = 3'd0;
    localparam logic [2:0] CFG_OCTAVE_NUMBER  = 3'd1;
    localparam logic [2:0] CFG_A4_PHASE_STEP  = 3'd2;
    localparam logic [2:0] CFG_HARMONIC_COUNT = 3'd3;
    localparam logic [2:0] CFG_NOTE_LENGTH    = 3'd4;
    localparam logic [2:0] CFG_BUFFER_LENGTH  = 3'd5;

    localparam logic [3:0]  RST_NOTE_NAME      = 4'd9;
    localparam logic [3:0]  RST_OCTAVE_NUMBER  = 4'd4;
    localparam logic [31:0] RST_A4_PHASE_STEP  = 32'd42852281;
    localparam logic [4:0]  RST_HARMONIC_COUNT = 5'd0;
    localparam logic [23:0] RST_NOTE_LENGTH    = 24'd0;
    localparam logic [24:0] RST_BUFFER_LENGTH  = 25'd1;

    localparam logic [4:0]  NOTE_BASE = 5'd12;
    localparam logic [3:0]  OCT_A4    = 4'd4;

    // Byte-serial divide by three: quotient digit = (v * RECIP3) >> RECIP3_SHIFT
    localparam logic [9:0]  RECIP3       = 10'd683;
    localparam int          RECIP3_SHIFT = 11;
    localparam int          DIGIT_W      = 8;
    localparam logic [2:0]  DIV_LAST     = 3'd5;

    localparam int          SINE_W       = 15;
    localparam logic [63:0] SINE_MAX     = 64'd32767;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          Q30_SHIFT    = 30;
    localparam int          TAYLOR_TERMS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_MUL,
        ST_STEP_DIV,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_step;
        logic div_digit;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic issue_done;
        logic busy;
        logic out_free;
    } t_status;

    function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0] t;
        longint      sum;
        logic [63:0] v;
        t   = x;
        sum = longint'(x);
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            t = (t * x) >> Q30_SHIFT;
            t = (t * x) >> Q30_SHIFT;
            t = t / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * SINE_MAX + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return SINE_W'(v);
    endfunction

endpackage

>>> src/ahs_ctrl.sv
// ---------------------------------------------------------------------------
// ahs_ctrl
// Sequencer of the synthesiser: input handshake, step division, harmonic
// issue, pipeline drain and result hand-over.
// ---------------------------------------------------------------------------
module ahs_ctrl import ahs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_digit;
    logic [2:0] n_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_digit <= '0;
        end else begin
            r_state <= n_state;
            r_digit <= n_digit;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_operation == OP_TICK)) begin
                    n_state = ST_STEP_MUL;
                end
            end
            ST_STEP_MUL: begin
                n_state = ST_STEP_DIV;
            end
            ST_STEP_DIV: begin
                if (r_digit == DIV_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.issue_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_digit = r_digit;
        if (r_state == ST_STEP_MUL) begin
            n_digit = '0;
        end else if (r_state == ST_STEP_DIV) begin
            n_digit = r_digit + 3'd1;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_STEP_MUL: begin
                o_cmd.load_step = 1'b1;
            end
            ST_STEP_DIV: begin
                o_cmd.div_digit = 1'b1;
            end
            ST_RUN: begin
                o_cmd.issue = !i_status.issue_done;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> src/ahs_datapath.sv
// ---------------------------------------------------------------------------
// ahs_datapath
// Configuration registers, harmonic tables, phase memory, step divider,
// sine/amplitude pipeline, saturating accumulator and result register.
// ---------------------------------------------------------------------------
module ahs_datapath import ahs_pkg::*; #(
    parameter int MAX_HARMONICS    = MAX_HARMONICS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int COUNTER_BITS     = COUNTER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_wr,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_load_wr,
    input  logic [3:0]         i_harmonic_index,
    input  logic [6:0]         i_harmonic_order,
    input  logic signed [15:0] i_harmonic_amplitude,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [23:0] o_sample_value,
    output logic [23:0]        o_sample_index,
    output logic               o_last_sample
);

    localparam int HW      = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int CW      = $clog2(MAX_HARMONICS + 1);
    localparam int CNT_W   = (COUNTER_BITS < 24) ? COUNTER_BITS : 24;
    localparam int QUARTER = ((SINE_TABLE_DEPTH / 4) > 0) ? (SINE_TABLE_DEPTH / 4) : 1;
    localparam int FULL    = 4 * QUARTER;
    localparam int IW      = $clog2(FULL);
    localparam int PW      = 32 + IW;
    localparam int RAW     = $clog2(QUARTER + 1);

    // configuration
    logic [3:0]  r_note;
    logic [3:0]  r_octave;
    logic [31:0] r_a4;
    logic [4:0]  r_hcount;
    logic [23:0] r_note_len;
    logic [24:0] r_buf_len;

    // tables and phase memory
    logic [6:0]         r_order_mem [MAX_HARMONICS];
    logic signed [15:0] r_amp_mem   [MAX_HARMONICS];
    logic [31:0]        r_phase_mem [MAX_HARMONICS];
    logic [MAX_HARMONICS-1:0] r_phase_vld;
    logic [SINE_W-1:0]  sine_rom    [QUARTER+1];

    // step divider
    logic [47:0] r_div;
    logic [1:0]  r_rem;
    logic [31:0] r_quo;
    logic [4:0]  note_mul;
    logic [36:0] num;
    logic [47:0] dividend;
    logic [9:0]  digit_v;
    logic [19:0] digit_p;
    logic [7:0]  digit_q;
    logic [9:0]  digit_r;

    // sample sequencing
    logic [CNT_W-1:0] r_count;
    logic [CW-1:0]    r_hidx;
    logic [CW-1:0]    count_eff;
    logic [24:0]      blen_eff;
    logic             w_last;
    logic             w_issue_done;

    // pipeline
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [31:0]        r_ph1;
    logic [6:0]         r_ord1;
    logic signed [15:0] r_amp1;
    logic               r_vld1;
    logic [HW-1:0]      r_idx1;
    logic [31:0]        phase_cur;
    logic [PW-1:0]      sidx_p;
    logic [IW-1:0]      r_sidx2;
    logic [31:0]        r_inc2;
    logic [31:0]        r_ph2;
    logic signed [15:0] r_amp2;
    logic [HW-1:0]      r_idx2;
    logic [1:0]         quad;
    logic [IW-1:0]      rem_idx;
    logic [RAW-1:0]     r_rom_addr3;
    logic               r_neg3;
    logic signed [15:0] r_amp3;
    logic [SINE_W-1:0]  r_mag4;
    logic               r_neg4;
    logic signed [15:0] r_amp4;
    logic signed [15:0] sine_s;
    logic signed [31:0] r_prod5;
    logic signed [32:0] term_r;
    logic signed [17:0] term;
    logic signed [24:0] sum_w;
    logic signed [23:0] sum_sat;
    logic signed [23:0] r_acc;

    logic               r_out_valid;
    logic signed [23:0] r_out_value;
    logic [23:0]        r_out_index;
    logic               r_out_last;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_sine
        localparam logic [63:0] X = HALF_PI_Q30 * 64'(k) / 64'(QUARTER);
        assign sine_rom[k] = sine_entry(X);
    end

    // fundamental step: floor(a4 * (12 + note) * 2^(oct-4) / 12)
    always_comb begin
        note_mul = NOTE_BASE + {1'b0, r_note};
        num      = 37'(r_a4) * 37'(note_mul);
        if (r_octave >= OCT_A4) begin
            dividend = {11'b0, num} << (r_octave - OCT_A4);
        end else begin
            dividend = {11'b0, num} >> (OCT_A4 - r_octave);
        end
        digit_v = {r_rem, r_div[47 -: DIGIT_W]};
        digit_p = 20'(digit_v) * 20'(RECIP3);
        digit_q = digit_p[RECIP3_SHIFT +: DIGIT_W];
        digit_r = digit_v - 10'(digit_q) * 10'd3;
    end

    always_comb begin
        count_eff    = (32'(r_hcount) > 32'(MAX_HARMONICS)) ? CW'(MAX_HARMONICS)
                                                            : CW'(r_hcount);
        blen_eff     = (r_buf_len == '0) ? 25'd1 : r_buf_len;
        w_last       = ((26'(r_count) + 26'd1) >= 26'(blen_eff)) || (&r_count);
        w_issue_done = (r_hidx == count_eff);
    end

    always_comb begin
        phase_cur = r_vld1 ? r_ph1 : '0;
        sidx_p    = PW'(phase_cur) * PW'(FULL);
        if (r_sidx2 >= IW'(3 * QUARTER)) begin
            quad    = 2'd3;
            rem_idx = r_sidx2 - IW'(3 * QUARTER);
        end else if (r_sidx2 >= IW'(2 * QUARTER)) begin
            quad    = 2'd2;
            rem_idx = r_sidx2 - IW'(2 * QUARTER);
        end else if (r_sidx2 >= IW'(QUARTER)) begin
            quad    = 2'd1;
            rem_idx = r_sidx2 - IW'(QUARTER);
        end else begin
            quad    = 2'd0;
            rem_idx = r_sidx2;
        end
        sine_s  = r_neg4 ? -$signed({1'b0, r_mag4}) : $signed({1'b0, r_mag4});
        term_r  = $signed({r_prod5[31], r_prod5}) + 33'sd16384;
        term    = term_r[32:15];
        sum_w   = $signed({r_acc[23], r_acc}) + $signed({{7{term[17]}}, term});
        if (sum_w[24] != sum_w[23]) begin
            sum_sat = sum_w[24] ? 24'sh800000 : 24'sh7fffff;
        end else begin
            sum_sat = sum_w[23:0];
        end
    end

    // tables and phase memory
    always_ff @(posedge i_clk) begin
        if (i_load_wr && (32'(i_harmonic_index) < 32'(MAX_HARMONICS))) begin
            r_order_mem[HW'(i_harmonic_index)] <= i_harmonic_order;
            r_amp_mem[HW'(i_harmonic_index)]   <= i_harmonic_amplitude;
        end
        if (r_v2 && !w_last) begin
            r_phase_mem[r_idx2] <= r_ph2 + r_inc2;
        end
        if (i_cmd.issue) begin
            r_ph1  <= r_phase_mem[r_hidx[HW-1:0]];
            r_ord1 <= r_order_mem[r_hidx[HW-1:0]];
            r_amp1 <= r_amp_mem[r_hidx[HW-1:0]];
            r_vld1 <= r_phase_vld[r_hidx[HW-1:0]];
            r_idx1 <= r_hidx[HW-1:0];
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_step) begin
            r_div <= dividend >> 2;
            r_rem <= '0;
        end else if (i_cmd.div_digit) begin
            r_div <= r_div << DIGIT_W;
            r_rem <= digit_r[1:0];
            r_quo <= {r_quo[31-DIGIT_W:0], digit_q};
        end

        r_sidx2 <= sidx_p[PW-1 -: IW];
        r_inc2  <= 32'(r_quo * 32'(r_ord1));
        r_ph2   <= phase_cur;
        r_amp2  <= r_amp1;
        r_idx2  <= r_idx1;

        r_rom_addr3 <= quad[0] ? RAW'(IW'(QUARTER) - rem_idx) : RAW'(rem_idx);
        r_neg3      <= quad[1];
        r_amp3      <= r_amp2;

        r_mag4 <= sine_rom[r_rom_addr3];
        r_neg4 <= r_neg3;
        r_amp4 <= r_amp3;

        r_prod5 <= sine_s * r_amp4;

        if (i_cmd.load_step) begin
            r_acc <= '0;
        end else if (r_v5) begin
            r_acc <= sum_sat;
        end

        if (i_cmd.finish) begin
            r_out_value <= (24'(r_count) >= r_note_len) ? '0 : r_acc;
            r_out_index <= 24'(r_count);
            r_out_last  <= w_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note      <= RST_NOTE_NAME;
            r_octave    <= RST_OCTAVE_NUMBER;
            r_a4        <= RST_A4_PHASE_STEP;
            r_hcount    <= RST_HARMONIC_COUNT;
            r_note_len  <= RST_NOTE_LENGTH;
            r_buf_len   <= RST_BUFFER_LENGTH;
            r_count     <= '0;
            r_phase_vld <= '0;
            r_hidx      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_NOTE_NAME:      r_note     <= i_cfg_data[3:0];
                    CFG_OCTAVE_NUMBER:  r_octave   <= i_cfg_data[3:0];
                    CFG_A4_PHASE_STEP:  r_a4       <= i_cfg_data;
                    CFG_HARMONIC_COUNT: r_hcount   <= i_cfg_data[4:0];
                    CFG_NOTE_LENGTH:    r_note_len <= i_cfg_data[23:0];
                    CFG_BUFFER_LENGTH:  r_buf_len  <= i_cfg_data[24:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load_step) begin
                r_hidx <= '0;
            end else if (i_cmd.issue) begin
                r_hidx <= r_hidx + CW'(1);
            end

            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;

            if (i_cmd.finish && w_last) begin
                r_phase_vld <= '0;
            end else if (r_v2 && !w_last) begin
                r_phase_vld[r_idx2] <= 1'b1;
            end

            if (i_cmd.finish) begin
                r_count <= w_last ? '0 : r_count + CNT_W'(1);
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.issue_done = w_issue_done;
    assign o_status.busy       = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_sample_index = r_out_index;
    assign o_last_sample  = r_out_last;

`ifndef NO_ASSERTIONS
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_v1 | r_v2 | r_v3 | r_v4 | r_v5))
        else $error("result taken before the pipeline drained");

    a_issue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> !w_issue_done)
        else $error("harmonic issued beyond the active count");

    a_render_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && w_last) |=> ((r_phase_vld == '0) && (r_count == '0)))
        else $error("phases or counter not cleared at end of render");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !w_last) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("sample counter did not advance by one");
`endif

endmodule

>>> src/additive_harmonic_synth_top.sv
// ---------------------------------------------------------------------------
// additive_harmonic_synth_top
// Additive synthesiser: a bank of harmonic oscillators summed per sample.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a load item writes one harmonic
// slot (order, amplitude); a tick item renders one sample.
// Output channel (o_out_valid / i_out_stall): one result per tick carrying
// the saturated sample, its index in the render and the last-sample flag.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready, index
// selects note, octave, A4 step, harmonic count, note and buffer length.
// A tick first runs the step multiply and the six-digit divide by twelve,
// then issues one harmonic per cycle into the phase/sine/multiply/
// accumulate pipeline, then drains it and hands the result over. The
// next item is taken the cycle after the result is registered.
// Reset restores the register defaults, zeroes all phases and the sample
// counter; harmonic slots hold nothing defined until loaded.
// A stalled result waits in the output register while the next item is
// taken; a following tick holds at its end until that register frees.
// ---------------------------------------------------------------------------
module additive_harmonic_synth_top import ahs_pkg::*; #(
    parameter int MAX_HARMONICS    = MAX_HARMONICS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int COUNTER_BITS     = COUNTER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [3:0]         i_harmonic_index,
    input  logic [6:0]         i_harmonic_order,
    input  logic signed [15:0] i_harmonic_amplitude,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample_value,
    output logic [23:0]        o_sample_index,
    output logic               o_last_sample,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    load_wr;

    assign o_cfg_ready = 1'b1;
    assign load_wr     = i_in_valid && !o_in_stall && (i_operation == OP_LOAD);

    ahs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    ahs_datapath #(
        .MAX_HARMONICS    (MAX_HARMONICS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .COUNTER_BITS     (COUNTER_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_wr             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_load_wr            (load_wr),
        .i_harmonic_index     (i_harmonic_index),
        .i_harmonic_order     (i_harmonic_order),
        .i_harmonic_amplitude (i_harmonic_amplitude),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_sample_value       (o_sample_value),
        .o_sample_index       (o_sample_index),
        .o_last_sample        (o_last_sample)
    );

endmodule
